### rtl/rsst_pkg.sv
// Shared types and constants for the rotation-synced strobe timer.
// No dependencies; used by rsst_cfg_if, rsst_edge_meter, rsst_shot_sched and the top level.
`timescale 1ns / 1ps

package rsst_pkg;

  // Default number of animation frames per rotation.
  localparam int FRAME_COUNT_DEF = 8;

  // An edge-scheduled shot whose delay is below this fires on the edge tick.
  localparam logic [31:0] IMMEDIATE_LIMIT = 32'd100;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH   = 2'd3;

  // Register reset values.
  localparam logic        AUTO_MODE_RST     = 1'b1;
  localparam logic [19:0] MANUAL_PERIOD_RST = 20'd33333;
  localparam logic [15:0] DEBOUNCE_RST      = 16'd1000;
  localparam logic [15:0] PULSE_WIDTH_RST   = 16'd100;

  // Edge meter to scheduler: debounced edge and the phase delay it asks for.
  typedef struct packed {
    logic        accepted;
    logic [31:0] delay;
  } edge_evt_t;

endpackage

### rtl/rsst_in_if.sv
// Request channel carrying one microsecond tick.
// Depends on nothing.
`timescale 1ns / 1ps

interface rsst_in_if;
  logic       valid;
  logic       ready;
  logic       ir_edge;
  logic [2:0] frame_select;

  modport source (output valid, output ir_edge, output frame_select, input ready);
  modport sink (input valid, input ir_edge, input frame_select, output ready);
endinterface

### rtl/rsst_out_if.sv
// Result channel: lamp level, edge flag and measured period for one tick.
// Depends on nothing.
`timescale 1ns / 1ps

interface rsst_out_if;
  logic        valid;
  logic        ready;
  logic        strobe_out;
  logic        edge_accepted;
  logic [31:0] period_us;

  modport source (output valid, output strobe_out, output edge_accepted,
                  output period_us, input ready);
  modport sink (input valid, input strobe_out, input edge_accepted,
                input period_us, output ready);
endinterface

### rtl/rsst_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on rsst_pkg for the field widths.
`timescale 1ns / 1ps

interface rsst_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rsst_pkg::CFG_IDX_W-1:0]  index;
  logic [rsst_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/rsst_edge_meter.sv
// Edge debounce and rotation period measurement; derives the phase delay.
// Depends on rsst_pkg (edge_evt_t).
`timescale 1ns / 1ps

module rsst_edge_meter #(
  parameter int FRAME_COUNT = rsst_pkg::FRAME_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                ir_edge,
  input  logic [2:0]          frame_select,
  input  logic [15:0]         debounce_us,
  output rsst_pkg::edge_evt_t evt,
  output logic [31:0]         period_next
);

  // elapsed / FRAME_COUNT fits in QW bits, remainder in RW bits.
  localparam int QW = 33 - $clog2(FRAME_COUNT + 1);
  localparam int RW = $clog2(FRAME_COUNT);
  localparam logic [RW-1:0] R_LAST = RW'(FRAME_COUNT - 1);

  // Ticks since the last accepted edge, kept with its quotient and remainder.
  logic [31:0] elapsed, elapsed_next;
  logic [QW-1:0] quot, quot_next;
  logic [RW-1:0] rem, rem_next;
  logic [31:0] period;
  logic        acc;

  assign acc = ir_edge && (elapsed >= {16'd0, debounce_us});

  always_comb begin
    period_next = period;
    if (acc) begin
      period_next  = elapsed;
      elapsed_next = 32'd1;
      quot_next    = '0;
      rem_next     = RW'(1);
    end else if (elapsed == '1) begin
      // counter wraps to zero
      elapsed_next = '0;
      quot_next    = '0;
      rem_next     = '0;
    end else if (rem == R_LAST) begin
      elapsed_next = elapsed + 32'd1;
      quot_next    = quot + QW'(1);
      rem_next     = '0;
    end else begin
      elapsed_next = elapsed + 32'd1;
      quot_next    = quot;
      rem_next     = rem + RW'(1);
    end
  end

  assign evt.accepted = acc;
  assign evt.delay = 32'({{(32-QW){1'b0}}, quot} * {29'd0, frame_select});

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      quot    <= '0;
      rem     <= '0;
      period  <= '0;
    end else if (step) begin
      elapsed <= elapsed_next;
      quot    <= quot_next;
      rem     <= rem_next;
      period  <= period_next;
    end
  end

  a_acc_restarts: assert property (@(posedge clk) disable iff (rst)
    step && acc |=> elapsed == 32'd1 && quot == '0)
    else $error("elapsed count not restarted after accepted edge");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem <= R_LAST)
    else $error("remainder out of range");

  a_period_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !(step && acc) |=> period == $past(period))
    else $error("period changed without an accepted edge");

endmodule

### rtl/rsst_shot_sched.sv
// Shot scheduling (auto and manual), pulse stretching and the tick counter.
// Depends on rsst_pkg (edge_evt_t, IMMEDIATE_LIMIT).
`timescale 1ns / 1ps

module rsst_shot_sched (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  rsst_pkg::edge_evt_t evt,
  input  logic                auto_mode,
  input  logic [19:0]         manual_period_us,
  input  logic [15:0]         pulse_width_us,
  output logic                lamp
);

  logic [31:0] time_now;
  logic        shot_pending, shot_pending_next;
  logic [31:0] shot_time, shot_time_next;
  logic [31:0] manual_last_shot, manual_last_shot_next;
  logic [15:0] pulse_left, pulse_left_next;

  logic        fire;
  logic        sched_now;
  logic        due;
  logic [31:0] since_shot;
  logic [31:0] man_elapsed;
  logic [15:0] pulse_load;

  assign since_shot  = time_now - shot_time;
  assign man_elapsed = time_now - manual_last_shot;

  always_comb begin
    fire                  = 1'b0;
    sched_now             = 1'b0;
    shot_pending_next     = shot_pending;
    shot_time_next        = shot_time;
    manual_last_shot_next = manual_last_shot;

    if (evt.accepted && auto_mode) begin
      if (evt.delay < rsst_pkg::IMMEDIATE_LIMIT) begin
        fire              = 1'b1;
        shot_pending_next = 1'b0;
      end else begin
        sched_now         = 1'b1;
        shot_pending_next = 1'b1;
        shot_time_next    = time_now + evt.delay;
      end
    end

    // Freshly scheduled shot is already due only if the delay wraps past
    // half the counter range.
    due = sched_now ? (evt.delay[31] && (evt.delay[30:0] != '0)) : !since_shot[31];

    if (auto_mode) begin
      if (shot_pending_next && due) begin
        fire              = 1'b1;
        shot_pending_next = 1'b0;
      end
    end else if (manual_period_us != '0) begin
      if (man_elapsed >= {12'd0, manual_period_us}) begin
        if (man_elapsed > {11'd0, manual_period_us, 1'b0}) begin
          manual_last_shot_next = time_now;  // fell behind: resync
        end else begin
          manual_last_shot_next = manual_last_shot + {12'd0, manual_period_us};
        end
        fire = 1'b1;
      end
    end

    pulse_load      = fire ? pulse_width_us : pulse_left;
    lamp            = (pulse_load != '0);
    pulse_left_next = lamp ? pulse_load - 16'd1 : pulse_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now         <= '0;
      shot_pending     <= 1'b0;
      shot_time        <= '0;
      manual_last_shot <= '0;
      pulse_left       <= '0;
    end else if (step) begin
      time_now         <= time_now + 32'd1;
      shot_pending     <= shot_pending_next;
      shot_time        <= shot_time_next;
      manual_last_shot <= manual_last_shot_next;
      pulse_left       <= pulse_left_next;
    end
  end

  a_manual_holds_shot: assert property (@(posedge clk) disable iff (rst)
    !rst && step && !auto_mode |=> shot_pending == $past(shot_pending))
    else $error("pending shot touched in manual mode");

  a_fire_loads_pulse: assert property (@(posedge clk) disable iff (rst)
    !rst && step && fire && pulse_width_us != '0
      |=> pulse_left == $past(pulse_width_us) - 16'd1)
    else $error("shot did not reload pulse");

  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !step |=> time_now == $past(time_now))
    else $error("tick counter advanced without a request");

endmodule

### rtl/rotation_synced_strobe_timer_core.sv
// Top level of the rotation-synced strobe timer: channels, configuration
// registers, input and result registers. Depends on rsst_pkg, the channel
// interfaces, rsst_edge_meter and rsst_shot_sched.
`timescale 1ns / 1ps

// Each request is one microsecond tick of the time base, carrying the
// infrared edge flag and the frame index; each request yields exactly one
// result (lamp level, edge-accepted flag, last rotation period). The block
// takes one request per clock, sustained while results are taken; the
// accepting edge loads the input register, and the step that follows takes
// one pass through the edge meter and shot scheduler into the result
// register. The rate is set by that single pass: all timer state (tick
// count, elapsed time since the last edge, pending shot, manual shot
// reference, pulse counter) is updated once per tick.
// Backpressure on the result side stalls the pass; while a result waits, the
// input register can still hold one more request.
// Configuration registers are written through cfg_wr (always ready) and
// should only change while no tick is in flight. The phase delay is
// (period / FRAME_COUNT) * frame_select, with the quotient tracked
// incrementally alongside the elapsed count, so no divider is present.

module rotation_synced_strobe_timer_core #(
  parameter int FRAME_COUNT = rsst_pkg::FRAME_COUNT_DEF
) (
  input logic             clk,
  input logic             rst,
  rsst_in_if.sink         req_in,
  rsst_out_if.source      res_out,
  rsst_cfg_if.sink        cfg_wr
);

  // configuration registers
  logic        auto_mode;
  logic [19:0] manual_period_us;
  logic [15:0] debounce_us;
  logic [15:0] pulse_width_us;

  // input register
  logic       in_valid;
  logic       in_edge;
  logic [2:0] in_frame;

  // result register
  logic        out_valid;
  logic        out_strobe;
  logic        out_edge_acc;
  logic [31:0] out_period;

  logic                step;
  rsst_pkg::edge_evt_t evt;
  logic [31:0]         period_next;
  logic                lamp;

  // process the held tick when the result slot is free or being drained
  assign step         = in_valid && (!out_valid || res_out.ready);
  assign req_in.ready = !in_valid || step;
  assign cfg_wr.ready = 1'b1;

  assign res_out.valid         = out_valid;
  assign res_out.strobe_out    = out_strobe;
  assign res_out.edge_accepted = out_edge_acc;
  assign res_out.period_us     = out_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode        <= rsst_pkg::AUTO_MODE_RST;
      manual_period_us <= rsst_pkg::MANUAL_PERIOD_RST;
      debounce_us      <= rsst_pkg::DEBOUNCE_RST;
      pulse_width_us   <= rsst_pkg::PULSE_WIDTH_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        rsst_pkg::REG_AUTO_MODE:     auto_mode        <= cfg_wr.data[0];
        rsst_pkg::REG_MANUAL_PERIOD: manual_period_us <= cfg_wr.data[19:0];
        rsst_pkg::REG_DEBOUNCE:      debounce_us      <= cfg_wr.data[15:0];
        rsst_pkg::REG_PULSE_WIDTH:   pulse_width_us   <= cfg_wr.data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_in.ready) begin
      in_valid <= req_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_in.valid && req_in.ready) begin
      in_edge  <= req_in.ir_edge;
      in_frame <= req_in.frame_select;
    end
  end

  rsst_edge_meter #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_edge_meter (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .ir_edge      (in_edge),
    .frame_select (in_frame),
    .debounce_us  (debounce_us),
    .evt          (evt),
    .period_next  (period_next)
  );

  rsst_shot_sched u_shot_sched (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .evt              (evt),
    .auto_mode        (auto_mode),
    .manual_period_us (manual_period_us),
    .pulse_width_us   (pulse_width_us),
    .lamp             (lamp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // period as updated by this tick's edge
  always_ff @(posedge clk) begin
    if (step) begin
      out_strobe   <= lamp;
      out_edge_acc <= evt.accepted;
      out_period   <= period_next;
    end
  end

  a_step_needs_item: assert property (@(posedge clk) disable iff (rst)
    step |-> in_valid)
    else $error("step without a held request");

  a_empty_takes_req: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> req_in.ready)
    else $error("empty input register refused a request");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    !rst && out_valid && !res_out.ready |=> out_valid)
    else $error("undelivered result dropped");

endmodule
